/* sv/gsri_pkg.sv */
`default_nettype none
package gsri_pkg;

   // bus access opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // bus window offsets
   localparam logic [7:0] ADDR_DATA      = 8'hC4;
   localparam logic [7:0] ADDR_DIRECTION = 8'hC6;
   localparam logic [7:0] ADDR_READ_EN   = 8'hC8;

   localparam logic [3:0] DIRECTION_MASK = 4'hF;
   localparam logic [7:0] CONTROL_MASK   = 8'h6A;

   // serial protocol phases
   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_READY   = 3'd1;
   localparam logic [2:0] PH_COMMAND = 3'd2;
   localparam logic [2:0] PH_READ    = 3'd3;
   localparam logic [2:0] PH_WRITE   = 3'd4;
   localparam logic [2:0] PH_END     = 3'd5;

   // rtc register numbers
   localparam logic [2:0] RTC_RESET    = 3'd0;
   localparam logic [2:0] RTC_CONTROL  = 3'd1;
   localparam logic [2:0] RTC_DATETIME = 3'd2;
   localparam logic [2:0] RTC_TIME     = 3'd3;
   localparam logic [2:0] RTC_ALARM_A  = 3'd4;
   localparam logic [2:0] RTC_ALARM_B  = 3'd5;
   localparam logic [2:0] RTC_IRQ      = 3'd6;
   localparam logic [2:0] RTC_SCRATCH  = 3'd7;

   // parameter bytes per register
   localparam logic [2:0] REG_SIZE [0:7] = '{3'd0, 3'd1, 3'd7, 3'd3, 3'd2, 3'd3, 3'd0, 3'd1};

   localparam logic [7:0] DATE_RESET [0:3] = '{8'h00, 8'h01, 8'h01, 8'h00};

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       op;
      logic [7:0] address;
      logic [7:0] write_data;
   } gsri_req_type;

   // time byte slot for a given register and byte number
   function automatic logic [1:0] gsri_time_index(input logic [2:0] reg_num,
                                                  input logic [2:0] n);
      logic [1:0] idx;
      idx = 2'd0;
      if (reg_num == RTC_DATETIME) begin
         case (n)
            3'd5:    idx = 2'd1;
            3'd6:    idx = 2'd2;
            default: idx = 2'd0;
         endcase
      end else begin
         case (n)
            3'd1, 3'd4, 3'd7: idx = 2'd1;
            3'd2, 3'd5:       idx = 2'd2;
            default:          idx = 2'd0;
         endcase
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

/* sv/gsri_protocol.sv */
`default_nettype none
module gsri_protocol (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gsri_pkg::gsri_req_type req,
   input  wire logic                  req_go,
   output logic [7:0]                 read_data
);
   import gsri_pkg::*;

   logic [3:0] dir_ff, dir_in;
   logic       flag_ff, flag_in;
   logic       clk_ff, clk_in;
   logic       sel_ff, sel_in;
   logic [7:0] sr_ff, sr_in;
   logic [3:0] bc_ff, bc_in;
   logic [2:0] byte_ff, byte_in;
   logic [2:0] reg_ff, reg_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] date_ff [0:3];
   logic [7:0] date_in [0:3];
   logic [7:0] time_ff [0:2];
   logic [7:0] time_in [0:2];

   logic [1:0] tidx;
   logic [7:0] cur_byte;
   logic       shift_ok;
   logic [7:0] sr_step;
   logic [3:0] bc_step;
   logic [2:0] byte_step;
   logic [2:0] cmd_reg;

   assign tidx = gsri_time_index(reg_ff, byte_ff);

   // byte currently presented by a read transfer
   always_comb begin
      case (reg_ff)
         RTC_CONTROL:  cur_byte = ctrl_ff;
         RTC_DATETIME: cur_byte = byte_ff[2] ? time_ff[tidx] : date_ff[byte_ff[1:0]];
         RTC_TIME:     cur_byte = time_ff[tidx];
         RTC_ALARM_A, RTC_ALARM_B, RTC_SCRATCH: cur_byte = 8'hFF;
         default:      cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      dir_in   = dir_ff;
      flag_in  = flag_ff;
      clk_in   = clk_ff;
      sel_in   = sel_ff;
      sr_in    = sr_ff;
      bc_in    = bc_ff;
      byte_in  = byte_ff;
      reg_in   = reg_ff;
      phase_in = phase_ff;
      ctrl_in  = ctrl_ff;
      date_in  = date_ff;
      time_in  = time_ff;
      read_data = 8'h00;
      shift_ok  = 1'b0;
      sr_step   = sr_ff;
      bc_step   = bc_ff;
      byte_step = byte_ff;
      cmd_reg   = reg_ff;

      if (req.op == OP_WRITE) begin
         unique case (req.address)
            ADDR_DIRECTION: dir_in  = req.write_data[3:0] & DIRECTION_MASK;
            ADDR_READ_EN:   flag_in = req.write_data[0];
            ADDR_DATA: begin
               if (dir_ff[2]) clk_in = req.write_data[2];
               if (dir_ff[0]) sel_in = req.write_data[0];
               shift_ok = dir_ff[1] && sel_in;
               unique case (phase_ff)
                  PH_START: begin
                     if (!clk_in && sel_in) phase_in = PH_READY;
                  end
                  PH_READY: begin
                     if (clk_in) begin
                        phase_in = PH_COMMAND;
                        sr_in    = 8'h00;
                        bc_in    = 4'd0;
                     end
                  end
                  PH_COMMAND: begin
                     // command shifts in msb first
                     if (shift_ok) begin
                        sr_step = {sr_ff[6:0], req.write_data[1]};
                        bc_step = bc_ff + 4'd1;
                     end
                     sr_in = sr_step;
                     bc_in = bc_step;
                     if (bc_step == BITS_PER_BYTE) begin
                        cmd_reg  = sr_step[3:1];
                        phase_in = sr_step[0] ? PH_READ : PH_WRITE;
                        reg_in   = cmd_reg;
                        sr_in    = 8'h00;
                        bc_in    = 4'd0;
                        byte_in  = 3'd0;
                        if (REG_SIZE[cmd_reg] == 3'd0) begin
                           if (cmd_reg == RTC_RESET) begin
                              ctrl_in = 8'h00;
                              date_in = DATE_RESET;
                              time_in = '{8'h00, 8'h00, 8'h00};
                           end
                           phase_in = PH_END;
                        end
                     end
                  end
                  PH_WRITE: begin
                     // parameter bytes shift in lsb first
                     if (shift_ok) begin
                        sr_step = {req.write_data[1], sr_ff[7:1]};
                        bc_step = bc_ff + 4'd1;
                     end
                     sr_in = sr_step;
                     bc_in = bc_step;
                     if (bc_step == BITS_PER_BYTE) begin
                        case (reg_ff)
                           RTC_CONTROL: ctrl_in = sr_step & CONTROL_MASK;
                           RTC_DATETIME: begin
                              if (byte_ff[2]) time_in[tidx] = sr_step;
                              else date_in[byte_ff[1:0]] = sr_step;
                           end
                           RTC_TIME: time_in[tidx] = sr_step;
                           default: ;
                        endcase
                        byte_step = byte_ff + 3'd1;
                        byte_in   = byte_step;
                        if (byte_step == REG_SIZE[reg_ff]) phase_in = PH_END;
                        sr_in = 8'h00;
                        bc_in = 4'd0;
                     end
                  end
                  PH_END: begin
                     if (!clk_in) phase_in = PH_START;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else begin
         unique case (req.address)
            ADDR_DIRECTION: read_data = {4'h0, dir_ff};
            ADDR_READ_EN:   read_data = {7'h00, flag_ff};
            ADDR_DATA: begin
               if (!dir_ff[1] && (phase_ff == PH_READ) && sel_ff) begin
                  read_data = {6'h00, cur_byte[bc_ff[2:0]], 1'b0};
                  bc_step   = bc_ff + 4'd1;
                  bc_in     = bc_step;
                  if (bc_step == BITS_PER_BYTE) begin
                     byte_step = byte_ff + 3'd1;
                     byte_in   = byte_step;
                     if (byte_step == REG_SIZE[reg_ff]) phase_in = PH_END;
                     bc_in = 4'd0;
                  end
               end
            end
            default: read_data = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= 4'h0;
         flag_ff  <= 1'b0;
         clk_ff   <= 1'b0;
         sel_ff   <= 1'b0;
         sr_ff    <= 8'h00;
         bc_ff    <= 4'd0;
         byte_ff  <= 3'd0;
         reg_ff   <= RTC_RESET;
         phase_ff <= PH_START;
         ctrl_ff  <= 8'h00;
         date_ff  <= DATE_RESET;
         time_ff  <= '{8'h00, 8'h00, 8'h00};
      end else if (req_go) begin
         dir_ff   <= dir_in;
         flag_ff  <= flag_in;
         clk_ff   <= clk_in;
         sel_ff   <= sel_in;
         sr_ff    <= sr_in;
         bc_ff    <= bc_in;
         byte_ff  <= byte_in;
         reg_ff   <= reg_in;
         phase_ff <= phase_in;
         ctrl_ff  <= ctrl_in;
         date_ff  <= date_in;
         time_ff  <= time_in;
      end
   end

endmodule
`default_nettype wire

/* sv/gpio_serial_rtc_interface_core.sv */
`default_nettype none
// channel  | direction | ports                                   | handshake
// req      | in        | req_op, req_address, req_write_data     | req_valid / req_stall
// rsp      | out       | rsp_read_data                           | rsp_valid / rsp_stall
//
// one transaction per cycle sustained while req_stall stays low; a read result reaches
// rsp through the input register, then the protocol step into the result register
// write transactions produce no result and pass the result register even while it is full
// synchronous active-high reset returns the rtc registers and the serial phase to defaults
// req_stall rises only while a read waits on a full, stalled result register
module gpio_serial_rtc_interface_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_address,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data
);
   import gsri_pkg::*;

   // input register
   logic         in_valid_ff;
   gsri_req_type in_req_ff;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff;

   logic         go;
   logic         is_read;
   logic [7:0]   step_data;

   assign is_read = (in_req_ff.op == OP_READ);

   // a held transaction steps when it makes no result or the result slot frees up
   assign go        = in_valid_ff && (!is_read || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= '{op: req_op, address: req_address, write_data: req_write_data};
      end
   end

   // serial rtc protocol engine and its register file
   gsri_protocol u_protocol (
      .clock     (clock),
      .reset     (reset),
      .req       (in_req_ff),
      .req_go    (go),
      .read_data (step_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go && is_read) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && is_read) begin
         rsp_data_ff <= step_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
`default_nettype wire

/* tb/gpio_serial_rtc_interface_core_test.sv */
`default_nettype none
module gpio_serial_rtc_interface_core_test;
   import gsri_pkg::*;

   // cycle budget for the whole run, far beyond the slowest legal run
   localparam int CYCLE_LIMIT = 400000;

   // shadow of the rtc bus window; predicts every read transaction
   class rtc_bus_scoreboard;
      logic [3:0] dir_bits;
      logic       read_enable;
      logic       clk_pin;
      logic       sel_pin;
      logic [7:0] shifter;
      logic [3:0] bit_cnt;
      logic [2:0] byte_cnt;
      logic [2:0] cur_reg;
      logic [2:0] phase;
      logic [7:0] control_byte;
      logic [7:0] date_reg [4];
      logic [7:0] time_reg [3];
      logic [7:0] expected_reads [$];
      int         failures;

      function new();
         dir_bits    = 4'h0;
         read_enable = 1'b0;
         clk_pin     = 1'b0;
         sel_pin     = 1'b0;
         shifter     = 8'h00;
         bit_cnt     = 4'd0;
         byte_cnt    = 3'd0;
         cur_reg     = RTC_RESET;
         phase       = PH_START;
         failures    = 0;
         restore_defaults();
      endfunction

      function void restore_defaults();
         control_byte = 8'h00;
         foreach (time_reg[i]) time_reg[i] = 8'h00;
         foreach (date_reg[i]) date_reg[i] = DATE_RESET[i];
      endfunction

      function logic [7:0] param_byte();
         int n;
         n = int'(byte_cnt);
         case (cur_reg)
            RTC_CONTROL:  return control_byte;
            RTC_DATETIME: return (n < 4) ? date_reg[n] : time_reg[(n - 4) % 3];
            RTC_TIME:     return time_reg[n % 3];
            RTC_ALARM_A, RTC_ALARM_B, RTC_SCRATCH: return 8'hFF;
            default:      return 8'h00;
         endcase
      endfunction

      function void store_param();
         int n;
         n = int'(byte_cnt);
         case (cur_reg)
            RTC_CONTROL: control_byte = shifter & CONTROL_MASK;
            RTC_DATETIME: begin
               if (n < 4) date_reg[n] = shifter;
               else time_reg[(n - 4) % 3] = shifter;
            end
            RTC_TIME: time_reg[n % 3] = shifter;
            default: ;
         endcase
      endfunction

      function logic [7:0] data_read();
         logic [7:0] cur;
         logic       b;
         if (dir_bits[1] || phase != PH_READ || !sel_pin) return 8'h00;
         cur = param_byte();
         b = cur[bit_cnt[2:0]];
         bit_cnt = bit_cnt + 4'd1;
         if (bit_cnt == BITS_PER_BYTE) begin
            byte_cnt = byte_cnt + 3'd1;
            if (byte_cnt == REG_SIZE[cur_reg]) phase = PH_END;
            bit_cnt = 4'd0;
         end
         return {6'b0, b, 1'b0};
      endfunction

      function void data_write(logic [7:0] v);
         logic shift_ok;
         if (dir_bits[2]) clk_pin = v[2];
         if (dir_bits[0]) sel_pin = v[0];
         shift_ok = dir_bits[1] && sel_pin;
         case (phase)
            PH_START: if (!clk_pin && sel_pin) phase = PH_READY;
            PH_READY: begin
               if (clk_pin) begin
                  phase   = PH_COMMAND;
                  shifter = 8'h00;
                  bit_cnt = 4'd0;
               end
            end
            PH_COMMAND: begin
               if (shift_ok) begin
                  shifter = {shifter[6:0], v[1]};
                  bit_cnt = bit_cnt + 4'd1;
               end
               if (bit_cnt == BITS_PER_BYTE) begin
                  phase    = shifter[0] ? PH_READ : PH_WRITE;
                  cur_reg  = shifter[3:1];
                  shifter  = 8'h00;
                  bit_cnt  = 4'd0;
                  byte_cnt = 3'd0;
                  if (REG_SIZE[cur_reg] == 3'd0) begin
                     if (cur_reg == RTC_RESET) restore_defaults();
                     phase = PH_END;
                  end
               end
            end
            PH_WRITE: begin
               if (shift_ok) begin
                  shifter = {v[1], shifter[7:1]};
                  bit_cnt = bit_cnt + 4'd1;
               end
               if (bit_cnt == BITS_PER_BYTE) begin
                  store_param();
                  byte_cnt = byte_cnt + 3'd1;
                  if (byte_cnt == REG_SIZE[cur_reg]) phase = PH_END;
                  shifter = 8'h00;
                  bit_cnt = 4'd0;
               end
            end
            PH_END: if (!clk_pin) phase = PH_START;
            default: ;
         endcase
      endfunction

      // accepted input transaction: update the shadow, queue a read result
      function void note_access(gsri_req_type acc);
         logic [7:0] r;
         if (acc.op == OP_WRITE) begin
            case (acc.address)
               ADDR_DATA:      data_write(acc.write_data);
               ADDR_DIRECTION: dir_bits = acc.write_data[3:0] & DIRECTION_MASK;
               ADDR_READ_EN:   read_enable = acc.write_data[0];
               default: ;
            endcase
         end else begin
            case (acc.address)
               ADDR_DATA:      r = data_read();
               ADDR_DIRECTION: r = {4'h0, dir_bits};
               ADDR_READ_EN:   r = {7'h00, read_enable};
               default:        r = 8'h00;
            endcase
            expected_reads.push_back(r);
         end
      endfunction

      function void check_read(logic [7:0] actual);
         logic [7:0] want;
         if (expected_reads.size() == 0) begin
            $error("read_data: expected nothing, actual %02h", actual);
            failures++;
            return;
         end
         want = expected_reads.pop_front();
         if (actual !== want) begin
            $error("read_data: expected %02h, actual %02h", want, actual);
            failures++;
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_op         = 1'b0;
   logic [7:0] req_address    = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_read_data;

   rtc_bus_scoreboard board;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int accepted_items = 0;
   int cycle_count    = 0;
   int step_budget    = 0;
   int hold_left      = 0;
   bit hold_req       = 1'b0;

   gpio_serial_rtc_interface_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 60;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // a result transaction completes on valid and no stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_read(rsp_read_data);
   end

   function automatic logic [7:0] rand_byte();
      logic [7:0] b;
      b = 8'($urandom);
      return b;
   endfunction

   // one input transaction; entered and left just after a falling edge
   task automatic send_access(input logic op, input logic [7:0] addr,
                              input logic [7:0] wdata);
      gsri_req_type acc;
      acc.op         = op;
      acc.address    = addr;
      acc.write_data = wdata;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_address    <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (req_stall);
      board.note_access(acc);
      accepted_items++;
      @(negedge clock);
   endtask

   // sender pause until every read result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // data pin transaction, counted against the budget of a cut-short transfer
   task automatic pin_access(input logic op, input logic [7:0] v);
      if (step_budget > 0) begin
         step_budget--;
         send_access(op, ADDR_DATA, v);
      end
   endtask

   // low three direction bits forced, the rest random
   task automatic set_direction(input logic [2:0] pins);
      logic [7:0] v;
      v = rand_byte();
      v[2:0] = pins;
      send_access(OP_WRITE, ADDR_DIRECTION, v);
   endtask

   // gentle noise never touches the pins or the directions
   task automatic noise_access(input bit gentle);
      logic [7:0] addr;
      logic       op;
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       addr = ADDR_DATA;
         1:       addr = ADDR_DIRECTION;
         2:       addr = ADDR_READ_EN;
         default: addr = rand_byte();
      endcase
      if (gentle && op == OP_WRITE && (addr == ADDR_DATA || addr == ADDR_DIRECTION))
         addr = ADDR_READ_EN;
      send_access(op, addr, rand_byte());
   endtask

   // walk the serial protocol back to the start phase from wherever it is
   task automatic resync();
      logic [7:0] v;
      int         guard;
      guard = 0;
      while (board.phase != PH_START && guard < 200) begin
         if (board.phase != PH_READ && board.dir_bits[2:0] != 3'b111) set_direction(3'b111);
         v = rand_byte();
         v[0] = 1'b1;
         case (board.phase)
            PH_READY: begin
               v[2] = 1'b1;
               send_access(OP_WRITE, ADDR_DATA, v);
            end
            PH_COMMAND, PH_WRITE: send_access(OP_WRITE, ADDR_DATA, v);
            PH_READ: begin
               // select must be high and data an input before bits come out
               if (!board.sel_pin || board.dir_bits[1] || !board.dir_bits[0]) begin
                  set_direction(3'b111);
                  send_access(OP_WRITE, ADDR_DATA, v);
                  set_direction(3'b101);
               end
               send_access(OP_READ, ADDR_DATA, rand_byte());
            end
            default: begin
               v[2] = 1'b0;
               send_access(OP_WRITE, ADDR_DATA, v);
            end
         endcase
         guard++;
      end
   endtask

   // one serial transfer: open, command, parameter bytes, close
   task automatic run_transfer(input logic [2:0] reg_num, input logic rw, input bit may_break);
      logic [7:0] cmd;
      logic [7:0] v;
      int         guard;
      resync();
      cmd = rand_byte();
      cmd[3:1] = reg_num;
      cmd[0] = rw;
      step_budget = (may_break && $urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 1000;
      if (board.dir_bits[2:0] != 3'b111) set_direction(3'b111);
      // select high with clock low, then clock high
      v = rand_byte(); v[0] = 1'b1; v[2] = 1'b0;
      pin_access(OP_WRITE, v);
      v = rand_byte(); v[0] = 1'b1; v[2] = 1'b1;
      pin_access(OP_WRITE, v);
      // command, msb first
      for (int i = 7; i >= 0; i--) begin
         v = rand_byte(); v[0] = 1'b1; v[1] = cmd[i];
         pin_access(OP_WRITE, v);
         if ($urandom_range(0, 9) == 0) noise_access(1'b1);
      end
      guard = 0;
      while (board.phase == PH_WRITE && step_budget > 0 && guard < 200) begin
         v = rand_byte(); v[0] = 1'b1;
         pin_access(OP_WRITE, v);
         if ($urandom_range(0, 9) == 0) noise_access(1'b1);
         guard++;
      end
      if (board.phase == PH_READ && step_budget > 0) begin
         // data pin still an output here, so this read returns zero
         if ($urandom_range(0, 3) == 0) pin_access(OP_READ, rand_byte());
         set_direction(3'b101);
      end
      while (board.phase == PH_READ && step_budget > 0 && guard < 200) begin
         case ($urandom_range(0, 19))
            0: begin
               // pin write inside a read transfer moves only clock and select
               v = rand_byte(); v[0] = 1'b1;
               pin_access(OP_WRITE, v);
            end
            1:       noise_access(1'b1);
            default: pin_access(OP_READ, rand_byte());
         endcase
         guard++;
      end
      // clock low closes the transfer
      v = rand_byte(); v[2] = 1'b0;
      pin_access(OP_WRITE, v);
   endtask

   initial begin
      logic [2:0] sweep_order [8];
      int         target;
      board = new();
      sweep_order = '{RTC_CONTROL, RTC_DATETIME, RTC_TIME, RTC_SCRATCH,
                      RTC_ALARM_A, RTC_ALARM_B, RTC_IRQ, RTC_RESET};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: window offsets, wide values, unknown offsets
      send_access(OP_READ,  ADDR_DATA,      8'h00);  // data read with no transfer open
      send_access(OP_READ,  ADDR_DIRECTION, 8'hFF);
      send_access(OP_READ,  ADDR_READ_EN,   8'hFF);
      send_access(OP_WRITE, ADDR_DATA,      8'hFF);  // no pin is an output yet
      send_access(OP_READ,  ADDR_DATA,      8'h00);
      send_access(OP_WRITE, ADDR_DIRECTION, 8'hFF);  // only the low nibble sticks
      send_access(OP_READ,  ADDR_DIRECTION, 8'h00);
      send_access(OP_WRITE, ADDR_DIRECTION, 8'hF0);
      send_access(OP_READ,  ADDR_DIRECTION, 8'h00);
      send_access(OP_WRITE, ADDR_READ_EN,   8'hFF);  // only bit 0 sticks
      send_access(OP_READ,  ADDR_READ_EN,   8'h00);
      send_access(OP_WRITE, ADDR_READ_EN,   8'hFE);
      send_access(OP_READ,  ADDR_READ_EN,   8'hFF);
      send_access(OP_WRITE, 8'h00,          8'hFF);  // unknown offsets are ignored
      send_access(OP_WRITE, 8'hFF,          8'h00);
      send_access(OP_WRITE, 8'hC9,          8'hFF);
      send_access(OP_READ,  8'h00,          8'hFF);
      send_access(OP_READ,  8'hFF,          8'h00);
      send_access(OP_READ,  8'hC5,          8'h55);
      send_access(OP_READ,  8'hC7,          8'hAA);
      send_access(OP_WRITE, ADDR_READ_EN,   8'h01);  // read enable does not gate data reads

      // every register written then read back, reset command last, then read again
      foreach (sweep_order[i]) begin
         run_transfer(sweep_order[i], 1'b0, 1'b0);
         run_transfer(sweep_order[i], 1'b1, 1'b0);
      end
      run_transfer(RTC_CONTROL,  1'b1, 1'b0);
      run_transfer(RTC_DATETIME, 1'b1, 1'b0);
      run_transfer(RTC_TIME,     1'b1, 1'b0);
      wait_drained();

      // random transfers with noise, four idling regimes
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin send_idle_pct = 8;  rsp_stall_pct = 8;  end
         endcase
         target = accepted_items + 100;
         while (accepted_items < target) begin
            if ($urandom_range(0, 99) < 85) begin
               run_transfer(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
               repeat ($urandom_range(1, 6)) noise_access(1'b0);
            end
         end
         if (p == 0) begin
            // result side holds off while reads keep coming, so the block backs up
            hold_req = 1'b1;
            repeat (24) send_access(OP_READ, ADDR_DIRECTION, rand_byte());
         end
         wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
